### src/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define PLT_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("peer table check failed");

// Checked at every rising edge, reset included.
`define PLT_ASSERT_ANY(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("peer table reset check failed");

`endif

### src/plt_pkg.sv
package plt_pkg;

  localparam int PLT_MAX_PEERS = 8;
  localparam int PLT_MASK_W    = 8;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_RECV  = 3'd1;
  localparam logic [2:0] OP_CHECK = 3'd2;
  localparam logic [2:0] OP_QUERY = 3'd3;
  localparam logic [2:0] OP_SEND  = 3'd4;

  typedef struct packed {
    logic [2:0]  op;
    logic [47:0] mac;
    logic [31:0] tmo;
    logic        gen;
    logic        glv;
    logic [2:0]  sel;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic alive;
    logic alive_nxt;
    logic gate;
    logic take;
    logic hit;
  } cell_stat_t;

endpackage

### src/peer_liveness_table.sv
// Peer liveness table. Each peer lives in one cell of a row of MAX_PEERS cells; a
// command word is latched on acceptance and executed once the output register can
// take its result, where every cell compares its MAC, age and timeout in parallel
// while a free-slot and a first-match token pass from cell 0 upward, so the lowest
// free cell takes an add and the lowest matching cell takes a receive. A word is
// accepted, then executed, and a new word is accepted in the cycle after execution.
// The result sits in an output register; a word may be accepted while it waits,
// but its execution holds until that result is taken. Result bit i of
// connected_mask shows peer i after the word, for the first eight peers.
module peer_liveness_table #(
  parameter int MAX_PEERS = plt_pkg::PLT_MAX_PEERS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // mac_addr[47:0] timeout_ms[79:48] gate_enabled[80] gate_level[81]
  // peer_sel[84:82] now_ms[116:85] zero[119:117]
  input  logic [119:0] in_tdata,
  // opcode[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // ok[0] peer_index[3:1] connected[4] connected_mask[12:5] zero[15:13]
  output logic [15:0]  out_tdata
);
  import plt_pkg::*;

  localparam int SHOWN = (MAX_PEERS < PLT_MASK_W) ? MAX_PEERS : PLT_MASK_W;

  cmd_t        cmd_r;
  logic        busy_r;
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic        commit;

  logic [MAX_PEERS:0] free_c;
  logic [MAX_PEERS:0] hit_c;
  cell_stat_t         stat [MAX_PEERS];

  logic                  ok_c;
  logic [2:0]            idx_c;
  logic                  con_c;
  logic [PLT_MASK_W-1:0] mask_c;
  logic [2:0]            claim_idx;
  logic                  sel_valid;
  logic                  sel_alive;
  logic                  sel_gate;

  assign in_tready = !busy_r;
  assign commit    = busy_r && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      busy_r <= 1'b1;
    end else if (commit) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r.op  <= in_tuser;
      cmd_r.mac <= in_tdata[47:0];
      cmd_r.tmo <= in_tdata[79:48];
      cmd_r.gen <= in_tdata[80];
      cmd_r.glv <= in_tdata[81];
      cmd_r.sel <= in_tdata[84:82];
      cmd_r.now <= in_tdata[116:85];
    end
  end

  assign free_c[0] = 1'b0;
  assign hit_c[0]  = 1'b0;

  for (genvar g = 0; g < MAX_PEERS; g++) begin : g_cell
    plt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd_r),
      .commit   (commit),
      .free_in  (free_c[g]),
      .hit_in   (hit_c[g]),
      .free_out (free_c[g+1]),
      .hit_out  (hit_c[g+1]),
      .stat     (stat[g])
    );
  end

  always_comb begin
    claim_idx = '0;
    sel_valid = 1'b0;
    sel_alive = 1'b0;
    sel_gate  = 1'b0;
    for (int i = 0; i < MAX_PEERS; i++) begin
      if (stat[i].take || stat[i].hit) begin
        claim_idx = claim_idx | 3'(i);
      end
      if ((i < PLT_MASK_W) && (3'(i) == cmd_r.sel)) begin
        sel_valid = stat[i].valid;
        sel_alive = stat[i].alive;
        sel_gate  = stat[i].gate;
      end
    end
  end

  always_comb begin
    mask_c = '0;
    for (int i = 0; i < SHOWN; i++) begin
      mask_c[i] = stat[i].alive_nxt;
    end
  end

  always_comb begin
    ok_c  = 1'b0;
    idx_c = '0;
    con_c = 1'b0;
    case (cmd_r.op)
      OP_ADD: begin
        ok_c  = free_c[MAX_PEERS];
        idx_c = claim_idx;
      end
      OP_RECV: begin
        ok_c  = hit_c[MAX_PEERS];
        idx_c = claim_idx;
        con_c = hit_c[MAX_PEERS];
      end
      OP_CHECK: begin
        ok_c = 1'b1;
      end
      OP_QUERY: begin
        idx_c = cmd_r.sel;
        ok_c  = sel_valid;
        con_c = sel_valid && sel_alive;
      end
      OP_SEND: begin
        idx_c = cmd_r.sel;
        ok_c  = sel_valid && !(sel_gate && !cmd_r.glv);
        con_c = sel_valid && sel_alive;
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= {3'b000, mask_c, con_c, idx_c, ok_c};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### src/plt_cell.sv
module plt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  plt_pkg::cmd_t      cmd,
  input  logic               commit,
  input  logic               free_in,
  input  logic               hit_in,
  output logic               free_out,
  output logic               hit_out,
  output plt_pkg::cell_stat_t stat
);
  import plt_pkg::*;

  logic        valid_r, valid_nxt;
  logic        alive_r, alive_nxt;
  logic [31:0] heard_r, heard_nxt;
  logic [47:0] mac_r;
  logic [31:0] tmo_r;
  logic        gate_r;

  logic        match;
  logic        take;
  logic        hit;
  logic [31:0] elapsed;
  logic        expired;

  assign match    = valid_r && (mac_r == cmd.mac);
  assign take     = (cmd.op == OP_ADD) && !valid_r && !free_in;
  assign hit      = (cmd.op == OP_RECV) && match && !hit_in;
  assign free_out = free_in | !valid_r;
  assign hit_out  = hit_in | match;

  // wrapping age of the last heartbeat
  assign elapsed = cmd.now - heard_r;
  assign expired = valid_r && (elapsed >= tmo_r);

  always_comb begin
    valid_nxt = valid_r | take;
    alive_nxt = alive_r;
    heard_nxt = heard_r;
    if (take) begin
      alive_nxt = 1'b0;
      heard_nxt = '0;
    end else if (hit) begin
      alive_nxt = 1'b1;
      heard_nxt = cmd.now;
    end else if ((cmd.op == OP_CHECK) && expired) begin
      alive_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      alive_r <= 1'b0;
      heard_r <= '0;
    end else if (commit) begin
      valid_r <= valid_nxt;
      alive_r <= alive_nxt;
      heard_r <= heard_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && take) begin
      mac_r  <= cmd.mac;
      tmo_r  <= cmd.tmo;
      gate_r <= cmd.gen;
    end
  end

  assign stat.valid     = valid_r;
  assign stat.alive     = alive_r;
  assign stat.alive_nxt = alive_nxt;
  assign stat.gate      = gate_r;
  assign stat.take      = take;
  assign stat.hit       = hit;

endmodule

### src/plt_checker.sv
`include "assert_macros.svh"

module plt_checker #(
  parameter int MAX_PEERS = plt_pkg::PLT_MAX_PEERS
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [15:0]  out_tdata
);
  import plt_pkg::*;

  localparam int SHOWN = (MAX_PEERS < PLT_MASK_W) ? MAX_PEERS : PLT_MASK_W;
  localparam logic [PLT_MASK_W-1:0] SHOWN_MASK =
    PLT_MASK_W'((9'd1 << SHOWN) - 9'd1);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // a waiting result holds still
  `PLT_ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata))
  // one word in flight: no acceptance right after one
  `PLT_ASSERT_CLK(a_one_inflight, clk, rst_n, in_acc |=> !in_tready)
  // no flag for a cell that does not exist
  `PLT_ASSERT_CLK(a_mask_range, clk, rst_n, out_tvalid |-> ((out_tdata[12:5] & ~SHOWN_MASK) == '0))
  // reset empties the result register
  `PLT_ASSERT_ANY(a_reset_empty, clk, !rst_n |=> !out_tvalid)

endmodule

bind peer_liveness_table plt_checker #(.MAX_PEERS(MAX_PEERS)) u_plt_checker (.*);
